FILE: rtl/core/tolerance_peak_trace_matcher_core_assert.svh
// Assertion macros shared by the trace matcher RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef TOLERANCE_PEAK_TRACE_MATCHER_CORE_ASSERT_SVH
`define TOLERANCE_PEAK_TRACE_MATCHER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TPTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/tptm_pkg.sv
// Package of the trace matcher: sizes, codes, cell link and control structs.
// No dependencies; every other file of the block but the assertion header imports it.
package tptm_pkg;

  localparam int TRACES = 64;
  localparam int RUNS = 16;
  localparam int MZ_W = 32;
  localparam int CNT_W = $clog2(RUNS + 1);
  localparam int TOT_W = $clog2(TRACES + 1);
  localparam int RC_W = 5;
  localparam int MINR_W = 5;
  localparam int OP_W = 2;
  localparam int RUN_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_PRUNE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MZ_TOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUNS = 1'b1;

  localparam logic [MZ_W-1:0] TOL_RESET = 32'd10486;
  localparam logic [MINR_W-1:0] MIN_RUNS_RESET = 5'd2;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic used;
    logic below;
    logic [MZ_W-1:0] gap;
    logic [MZ_W-1:0] key;
    logic [RUNS-1:0] mask;
  } tptm_link_t;

  // Commands and broadcast data from the sequencer to every cell.
  typedef struct packed {
    logic clr;
    logic cmp;
    logic upd;
    logic ins;
    logic pop;
    logic keep;
    logic [MZ_W-1:0] mz;
    logic [MZ_W-1:0] tol;
    logic [RUNS-1:0] run_bit;
    logic [MZ_W-1:0] pop_key;
    logic [RUNS-1:0] pop_mask;
  } tptm_ctl_t;

  // Run count as reported, saturated at the field's limit.
  function automatic logic [RC_W-1:0] sat_runs(input logic [CNT_W-1:0] c);
    if (32'(c) > 32'd31) begin
      return 5'd31;
    end
    return RC_W'(c);
  endfunction

endpackage

FILE: rtl/core/tptm_if.sv
// Valid/ready channel interfaces for the trace matcher's input and result streams.
// Depends on tptm_pkg for field widths.
interface tptm_in_if import tptm_pkg::*; ();
  logic valid;
  logic ready;
  logic [OP_W-1:0] op;
  logic [RUN_W-1:0] run_id;
  logic [MZ_W-1:0] fragment_mz;

  modport source (output valid, op, run_id, fragment_mz, input ready);
  modport sink (input valid, op, run_id, fragment_mz, output ready);
endinterface

interface tptm_out_if import tptm_pkg::*; ();
  logic valid;
  logic ready;
  logic matched;
  logic new_trace;
  logic dropped_full;
  logic trace_valid;
  logic [MZ_W-1:0] trace_mz;
  logic [RC_W-1:0] run_count;
  logic last;

  modport source (output valid, matched, new_trace, dropped_full, trace_valid, trace_mz,
                  run_count, last, input ready);
  modport sink (input valid, matched, new_trace, dropped_full, trace_valid, trace_mz,
                run_count, last, output ready);
endinterface

FILE: rtl/core/tolerance_peak_trace_matcher_core.sv
// Trace matcher: a sorted row of TRACES cells groups fragment peaks by m/z across runs.
// An insert passes through the transfer cycle, in which every cell compares its key,
// an update cycle that also shifts the row, and a cycle that reads the chosen cell into
// the output register. A prune passes through the transfer cycle, a step per stored trace
// as the row rotates through the front cell, and S_PFIN, which loads the last result; a
// clear passes through the transfer cycle and S_CLR. A result waiting in the output
// register stalls the sequencer. The next item is taken as soon as the previous one has
// loaded its last result, even while that result waits in the output register.
// Depends on tptm_pkg, tptm_if, tptm_cell and the assertion header.
`include "tolerance_peak_trace_matcher_core_assert.svh"

module tolerance_peak_trace_matcher_core import tptm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tptm_in_if.sink               in_ch,
  tptm_out_if.source            out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD = 3'd1;
  localparam logic [2:0] S_RPT = 3'd2;
  localparam logic [2:0] S_PRUNE = 3'd3;
  localparam logic [2:0] S_PFIN = 3'd4;
  localparam logic [2:0] S_CLR = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [MZ_W-1:0] mz_tolerance;
  logic [MINR_W-1:0] min_runs;

  logic [MZ_W-1:0] mz_reg;
  logic [RUN_W-1:0] run_reg;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] step_cnt;
  logic res_match;
  logic res_drop;

  logic pend_valid;
  logic [MZ_W-1:0] pend_key;
  logic [RC_W-1:0] pend_cnt;

  logic out_valid;
  logic out_free;
  logic out_load;
  logic o_matched;
  logic o_new;
  logic o_drop;
  logic o_tvalid;
  logic [MZ_W-1:0] o_mz;
  logic [RC_W-1:0] o_cnt;
  logic o_last;

  tptm_ctl_t ctl;
  tptm_link_t link [TRACES];
  logic [CNT_W-1:0] cnt [TRACES];
  logic [TRACES-1:0] hit_vec;
  logic [TRACES-1:0] flag_vec;

  logic any_match;
  logic full;
  logic in_xfer;
  logic keep0;
  logic stall;
  logic [MZ_W-1:0] sel_key;
  logic [CNT_W-1:0] sel_cnt;

  assign in_ch.ready = (state == S_IDLE);
  assign in_xfer = in_ch.valid & in_ch.ready;
  assign out_free = ~out_valid | out_ch.ready;
  assign any_match = |hit_vec;
  assign full = (total == TOT_W'(TRACES));
  assign keep0 = (8'(cnt[0]) >= 8'(min_runs));
  assign stall = keep0 & pend_valid & ~out_free;

  // Broadcast commands to the cell row.
  always_comb begin
    ctl = '0;
    ctl.clr = in_xfer & (in_ch.op == OP_CLEAR);
    ctl.cmp = in_xfer & (in_ch.op == OP_INSERT);
    ctl.upd = (state == S_UPD);
    ctl.ins = ~any_match & ~full;
    ctl.pop = (state == S_PRUNE) & (step_cnt != '0) & ~stall;
    ctl.keep = keep0;
    ctl.mz = (state == S_IDLE) ? in_ch.fragment_mz : mz_reg;
    ctl.tol = mz_tolerance;
    ctl.run_bit = (32'(run_reg) < RUNS) ? ({{(RUNS-1){1'b0}}, 1'b1} << run_reg) : '0;
    ctl.pop_key = link[0].key;
    ctl.pop_mask = link[0].mask;
  end

  // The sorted row of cells.
  for (genvar i = 0; i < TRACES; i++) begin : g_cell
    tptm_link_t prv;
    tptm_link_t nxt;
    if (i == 0) begin : g_first
      assign prv = '0;
    end else begin : g_prv
      assign prv = link[i-1];
    end
    if (i == TRACES - 1) begin : g_final
      assign nxt = '0;
    end else begin : g_nxt
      assign nxt = link[i+1];
    end
    tptm_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .head (i == 0),
      .ctl  (ctl),
      .prv  (prv),
      .nxt  (nxt),
      .link (link[i]),
      .hit  (hit_vec[i]),
      .flag (flag_vec[i]),
      .cnt  (cnt[i])
    );
  end

  // Read out the one flagged cell for an insert result.
  always_comb begin
    sel_key = '0;
    sel_cnt = '0;
    for (int i = 0; i < TRACES; i++) begin
      sel_key = sel_key | ({MZ_W{flag_vec[i]}} & link[i].key);
      sel_cnt = sel_cnt | ({CNT_W{flag_vec[i]}} & cnt[i]);
    end
  end

  // Sequencer and what it loads into the output register.
  always_comb begin
    state_next = state;
    out_load = 1'b0;
    o_matched = 1'b0;
    o_new = 1'b0;
    o_drop = 1'b0;
    o_tvalid = 1'b0;
    o_mz = '0;
    o_cnt = '0;
    o_last = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_ch.op)
            OP_INSERT: state_next = S_UPD;
            OP_PRUNE: state_next = S_PRUNE;
            OP_CLEAR: state_next = S_CLR;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_UPD: begin
        state_next = S_RPT;
      end
      S_RPT: begin
        if (out_free) begin
          out_load = 1'b1;
          o_matched = res_match;
          o_new = ~res_match & ~res_drop;
          o_drop = res_drop;
          o_tvalid = ~res_drop;
          o_mz = res_drop ? '0 : sel_key;
          o_cnt = res_drop ? '0 : sat_runs(sel_cnt);
          state_next = S_IDLE;
        end
      end
      S_PRUNE: begin
        if (step_cnt == '0) begin
          state_next = S_PFIN;
        end else if (~stall && keep0 && pend_valid) begin
          out_load = 1'b1;
          o_tvalid = 1'b1;
          o_mz = pend_key;
          o_cnt = pend_cnt;
          o_last = 1'b0;
        end
      end
      S_PFIN: begin
        if (out_free) begin
          out_load = 1'b1;
          o_tvalid = pend_valid;
          o_mz = pend_valid ? pend_key : '0;
          o_cnt = pend_valid ? pend_cnt : '0;
          state_next = S_IDLE;
        end
      end
      S_CLR: begin
        if (out_free) begin
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      step_cnt <= '0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
      mz_tolerance <= TOL_RESET;
      min_runs <= MIN_RUNS_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_MZ_TOL: mz_tolerance <= cfg_data;
          REG_MIN_RUNS: min_runs <= cfg_data[MINR_W-1:0];
          default: ;
        endcase
      end
      if (ctl.clr) begin
        total <= '0;
      end else if (in_xfer && in_ch.op == OP_PRUNE) begin
        step_cnt <= total;
        pend_valid <= 1'b0;
      end else if (ctl.upd && ctl.ins) begin
        total <= total + 1'b1;
      end else if (ctl.pop) begin
        step_cnt <= step_cnt - 1'b1;
        total <= total - 1'b1 + TOT_W'(keep0);
        if (keep0) begin
          pend_valid <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mz_reg <= in_ch.fragment_mz;
      run_reg <= in_ch.run_id;
    end
    if (ctl.upd) begin
      res_match <= any_match;
      res_drop <= ~any_match & full;
    end
    if (ctl.pop && keep0) begin
      pend_key <= link[0].key;
      pend_cnt <= sat_runs(cnt[0]);
    end
    if (out_load) begin
      out_ch.matched <= o_matched;
      out_ch.new_trace <= o_new;
      out_ch.dropped_full <= o_drop;
      out_ch.trace_valid <= o_tvalid;
      out_ch.trace_mz <= o_mz;
      out_ch.run_count <= o_cnt;
      out_ch.last <= o_last;
    end
  end

  assign out_ch.valid = out_valid;

  // Checks on the row and the sequencer.
  `TPTM_ASSERT_NOW(a_total_range, 1'b1, total <= TOT_W'(TRACES), "trace count above capacity")
  `TPTM_ASSERT_NOW(a_single_hit, state == S_UPD, $onehot0(hit_vec), "more than one cell matched")
  `TPTM_ASSERT_NOW(a_single_flag, state == S_RPT, $onehot0(flag_vec), "more than one cell flagged")
  `TPTM_ASSERT_NOW(a_load_free, out_load && out_valid, out_ch.ready, "result overwritten")
  `TPTM_ASSERT_NEXT(a_pop_count, ctl.pop, step_cnt == $past(step_cnt) - 1'b1,
                    "prune step counter out of step")

endmodule

FILE: rtl/core/tptm_cell.sv
// One slot of the sorted trace row: key, run mask, and the nearest-key decision.
// Depends on tptm_pkg; talks only to its two neighbors and the broadcast control.
module tptm_cell import tptm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             head,
  input  tptm_ctl_t        ctl,
  input  tptm_link_t       prv,
  input  tptm_link_t       nxt,
  output tptm_link_t       link,
  output logic             hit,
  output logic             flag,
  output logic [CNT_W-1:0] cnt
);

  logic [MZ_W-1:0] key;
  logic [RUNS-1:0] mask;
  logic used;
  logic lt;
  logic [MZ_W-1:0] gap;

  logic below;
  logic lower_pick;
  logic upper_pick;
  logic pos;
  logic sh;
  logic push;

  // Slots with a key under the fragment form a prefix of the row.
  assign below = used & lt;

  // Nearest key: the last slot below or the first slot at or above; ties go low.
  assign lower_pick = below & ~nxt.below & (~nxt.used | (gap <= nxt.gap));
  assign upper_pick = used & ~lt & (head | prv.below) & (head | (prv.gap > gap));
  assign hit = (lower_pick | upper_pick) & (gap <= ctl.tol);

  // Insert point is the first slot not below; slots after it move up by one.
  assign pos = (head | prv.below) & ~below;
  assign sh = ~head & ~prv.below;

  // During pruning the tail slot takes the entry popped off the front.
  assign push = used & ~nxt.used;

  assign link = '{used: used, below: below, gap: gap, key: key, mask: mask};

  // Distinct runs recorded in this slot.
  always_comb begin
    cnt = '0;
    for (int b = 0; b < RUNS; b++) begin
      cnt = cnt + CNT_W'(mask[b]);
    end
  end

  // Control state of the slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      flag <= 1'b0;
    end else if (ctl.clr) begin
      used <= 1'b0;
    end else if (ctl.upd) begin
      flag <= hit | (pos & ctl.ins);
      if (ctl.ins) begin
        if (pos) begin
          used <= 1'b1;
        end else if (sh) begin
          used <= prv.used;
        end
      end
    end else if (ctl.pop) begin
      used <= push ? ctl.keep : nxt.used;
    end
  end

  // Payload of the slot.
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt <= key < ctl.mz;
      gap <= (key < ctl.mz) ? (ctl.mz - key) : (key - ctl.mz);
    end else if (ctl.upd) begin
      if (hit) begin
        mask <= mask | ctl.run_bit;
      end else if (ctl.ins) begin
        if (pos) begin
          key <= ctl.mz;
          mask <= ctl.run_bit;
        end else if (sh) begin
          key <= prv.key;
          mask <= prv.mask;
        end
      end
    end else if (ctl.pop) begin
      if (push) begin
        key <= ctl.pop_key;
        mask <= ctl.pop_mask;
      end else begin
        key <= nxt.key;
        mask <= nxt.mask;
      end
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for tolerance_peak_trace_matcher_core: sorted trace table,
// tolerance matching, pruning by run count, clearing. Depends on tptm_pkg and tptm_if.
module testbench;
  import tptm_pkg::*;

  // The op code that the block ignores.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // Cycles the block may still be busy after its last result.
  localparam int SETTLE_CYCLES = TRACES + 8;
  localparam int ITEM_TARGET = 410;
  localparam int MAX_SHOWN = 40;

  typedef struct packed {
    logic matched;
    logic new_trace;
    logic dropped_full;
    logic trace_valid;
    logic [MZ_W-1:0] trace_mz;
    logic [RC_W-1:0] run_count;
    logic last;
  } trace_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tptm_in_if in_ch ();
  tptm_out_if out_ch ();

  tolerance_peak_trace_matcher_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of the trace table and of the registers.
  logic [MZ_W-1:0] shadow_key [TRACES];
  logic [RUNS-1:0] shadow_mask [TRACES];
  int shadow_total;
  logic [MZ_W-1:0] shadow_tol;
  int shadow_min_runs;

  trace_result_t pending_results[$];
  int mismatch_count;
  int result_index;
  int items_sent;
  bit steady_flow;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit.
  initial begin
    #20_000_000;
    $display("** tolerance_peak_trace_matcher_core: FAILED **");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Works out the results of one accepted item and updates the shadow table.
  function automatic void predict_item(input logic [OP_W-1:0] op,
                                       input logic [RUN_W-1:0] run,
                                       input logic [MZ_W-1:0] mz);
    int lb;
    int pick;
    int kept;
    logic [MZ_W-1:0] gap;
    logic [MZ_W-1:0] up;
    logic [MZ_W-1:0] down;
    logic [RUNS-1:0] run_mask;
    bit hit;
    trace_result_t r;
    r = '0;
    r.last = 1'b1;
    run_mask = '0;
    run_mask[run] = 1'b1;
    case (op)
      OP_INSERT: begin
        lb = 0;
        pick = 0;
        gap = '0;
        hit = 1'b0;
        while (lb < shadow_total && shadow_key[lb] < mz) lb++;
        // Nearest stored key; on a tie the lower key wins.
        if (shadow_total > 0) begin
          if (lb == shadow_total) begin
            pick = lb - 1;
            gap = mz - shadow_key[pick];
          end else if (lb == 0) begin
            pick = 0;
            gap = shadow_key[0] - mz;
          end else begin
            up = shadow_key[lb] - mz;
            down = mz - shadow_key[lb - 1];
            if (down > up) begin
              pick = lb;
              gap = up;
            end else begin
              pick = lb - 1;
              gap = down;
            end
          end
          hit = (gap <= shadow_tol);
        end
        if (hit) begin
          shadow_mask[pick] |= run_mask;
          r.matched = 1'b1;
          r.trace_valid = 1'b1;
          r.trace_mz = shadow_key[pick];
          r.run_count = RC_W'($countones(shadow_mask[pick]));
        end else if (shadow_total >= TRACES) begin
          r.dropped_full = 1'b1;
        end else begin
          for (int i = shadow_total; i > lb; i--) begin
            shadow_key[i] = shadow_key[i - 1];
            shadow_mask[i] = shadow_mask[i - 1];
          end
          shadow_key[lb] = mz;
          shadow_mask[lb] = run_mask;
          shadow_total++;
          r.new_trace = 1'b1;
          r.trace_valid = 1'b1;
          r.trace_mz = mz;
          r.run_count = RC_W'($countones(run_mask));
        end
        pending_results = {pending_results, r};
      end
      OP_PRUNE: begin
        kept = 0;
        for (int i = 0; i < shadow_total; i++) begin
          if ($countones(shadow_mask[i]) >= shadow_min_runs) begin
            shadow_key[kept] = shadow_key[i];
            shadow_mask[kept] = shadow_mask[i];
            kept++;
          end
        end
        shadow_total = kept;
        if (kept == 0) begin
          pending_results = {pending_results, r};
        end
        // One listing line per survivor, in key order.
        for (int k = 0; k < kept; k++) begin
          r.trace_valid = 1'b1;
          r.trace_mz = shadow_key[k];
          r.run_count = RC_W'($countones(shadow_mask[k]));
          r.last = (k == kept - 1);
          pending_results = {pending_results, r};
        end
      end
      OP_CLEAR: begin
        shadow_total = 0;
        pending_results = {pending_results, r};
      end
      default: begin
        // Unused op: no result and no change.
      end
    endcase
  endfunction

  // Sends one item, with random idle cycles before it.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [RUN_W-1:0] run,
                           input logic [MZ_W-1:0] mz);
    while (!steady_flow && $urandom_range(0, 99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.run_id <= run;
    in_ch.fragment_mz <= mz;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(op, run, mz);
    if (op != OP_UNUSED) begin
      items_sent++;
    end
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Waits until the block is idle, so that registers may be written.
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == REG_MZ_TOL) begin
      shadow_tol = data;
    end else begin
      shadow_min_runs = int'(data[MINR_W-1:0]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Fragment m/z: mostly near a stored key, sometimes at the extremes.
  function automatic logic [MZ_W-1:0] pick_mz();
    logic [MZ_W-1:0] span;
    int sel;
    sel = $urandom_range(0, 99);
    span = (shadow_tol > 32'd200000) ? 32'd200000 : shadow_tol;
    if (shadow_total > 0 && sel < 60) begin
      return shadow_key[$urandom_range(0, shadow_total - 1)]
             + MZ_W'($urandom_range(0, 2 * span + 1)) - span;
    end else if (sel < 70) begin
      return '0;
    end else if (sel < 80) begin
      return '1;
    end
    return $urandom;
  endfunction

  function automatic logic [MZ_W-1:0] pick_tolerance();
    case ($urandom_range(0, 3))
      0: return TOL_RESET;
      1: return $urandom_range(1, 1 << 16);
      2: return $urandom_range(1 << 16, 1 << 22);
      default: return '0;
    endcase
  endfunction

  // Result checker; it also drives the result ready with random stalls.
  initial begin : result_monitor
    trace_result_t got;
    trace_result_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got.matched = out_ch.matched;
        got.new_trace = out_ch.new_trace;
        got.dropped_full = out_ch.dropped_full;
        got.trace_valid = out_ch.trace_valid;
        got.trace_mz = out_ch.trace_mz;
        got.run_count = out_ch.run_count;
        got.last = out_ch.last;
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with none expected", result_index));
        end else begin
          want = pending_results.pop_front();
          if (got.matched !== want.matched)
            flag_mismatch($sformatf("result %0d matched %b, want %b",
                                    result_index, got.matched, want.matched));
          if (got.new_trace !== want.new_trace)
            flag_mismatch($sformatf("result %0d new_trace %b, want %b",
                                    result_index, got.new_trace, want.new_trace));
          if (got.dropped_full !== want.dropped_full)
            flag_mismatch($sformatf("result %0d dropped_full %b, want %b",
                                    result_index, got.dropped_full, want.dropped_full));
          if (got.trace_valid !== want.trace_valid)
            flag_mismatch($sformatf("result %0d trace_valid %b, want %b",
                                    result_index, got.trace_valid, want.trace_valid));
          if (got.trace_mz !== want.trace_mz)
            flag_mismatch($sformatf("result %0d trace_mz %h, want %h",
                                    result_index, got.trace_mz, want.trace_mz));
          if (got.run_count !== want.run_count)
            flag_mismatch($sformatf("result %0d run_count %0d, want %0d",
                                    result_index, got.run_count, want.run_count));
          if (got.last !== want.last)
            flag_mismatch($sformatf("result %0d last %b, want %b",
                                    result_index, got.last, want.last));
        end
        result_index++;
      end
      out_ch.ready <= !rst && (steady_flow || $urandom_range(0, 99) >= 34);
    end
  end

  // Field extremes, exact keys, ties, the tolerance boundary and every op.
  task automatic test_directed();
    logic [MZ_W-1:0] a;
    a = 32'h0010_0000;
    send_item(OP_CLEAR, 4'd0, '0);
    send_item(OP_PRUNE, 4'd15, '1);
    send_item(OP_UNUSED, 4'd15, '1);
    send_item(OP_INSERT, 4'd0, '0);
    send_item(OP_INSERT, 4'd15, '1);
    send_item(OP_INSERT, 4'd15, '0);
    send_item(OP_INSERT, 4'd0, '1);
    send_item(OP_INSERT, 4'd1, a);
    send_item(OP_INSERT, 4'd2, a + 32'd20000);
    // Equal distance to both neighbors goes to the lower key.
    send_item(OP_INSERT, 4'd3, a + 32'd10000);
    send_item(OP_INSERT, 4'd4, a + 32'd10001);
    // Exactly at the tolerance still matches; one more makes a new trace.
    send_item(OP_INSERT, 4'd5, a - TOL_RESET);
    send_item(OP_INSERT, 4'd6, a - TOL_RESET - 32'd1);
    send_item(OP_INSERT, 4'd7, a + 32'd20000 + TOL_RESET + 32'd1);
    send_item(OP_PRUNE, 4'd0, '0);
    send_item(OP_UNUSED, 4'd0, '0);
    send_item(OP_PRUNE, 4'd0, '0);
    send_item(OP_CLEAR, 4'd15, '1);
    send_item(OP_INSERT, 4'd9, a);
  endtask

  // Tolerance at zero and at its maximum, min_runs below and above the run range.
  task automatic test_config_extremes();
    logic [MZ_W-1:0] a;
    a = $urandom;
    settle();
    write_reg(REG_MZ_TOL, '0);
    write_reg(REG_MIN_RUNS, 32'd1);
    send_item(OP_INSERT, 4'd3, a);
    send_item(OP_INSERT, 4'd8, a);
    send_item(OP_INSERT, 4'd3, a + 32'd1);
    send_item(OP_INSERT, 4'd12, a - 32'd1);
    send_item(OP_PRUNE, 4'd0, '0);
    settle();
    write_reg(REG_MIN_RUNS, 32'd0);
    send_item(OP_PRUNE, 4'd0, '0);
    settle();
    write_reg(REG_MIN_RUNS, 32'd31);
    send_item(OP_PRUNE, 4'd0, '0);
    settle();
    write_reg(REG_MZ_TOL, '1);
    write_reg(REG_MIN_RUNS, 32'd16);
    for (int r = 0; r < RUNS; r++) begin
      send_item(OP_INSERT, RUN_W'(r), $urandom);
    end
    send_item(OP_PRUNE, 4'd0, '0);
    settle();
    write_reg(REG_MIN_RUNS, 32'd17);
    send_item(OP_PRUNE, 4'd0, '0);
  endtask

  // Batches of peaks seen across a few runs, each ending in a prune.
  task automatic test_run_groups();
    logic [MZ_W-1:0] bases [16];
    logic [MZ_W-1:0] span;
    logic [MZ_W-1:0] off;
    logic [RUN_W-1:0] run;
    int nbase;
    int nrun;
    int sel;
    for (int b = 0; b < 8; b++) begin
      settle();
      write_reg(REG_MZ_TOL, pick_tolerance() | 32'd2);
      write_reg(REG_MIN_RUNS, $urandom_range(1, 4));
      nbase = $urandom_range(3, 12);
      nrun = $urandom_range(1, 5);
      span = shadow_tol >> 1;
      for (int i = 0; i < nbase; i++) begin
        bases[i] = $urandom;
      end
      for (int r = 0; r < nrun; r++) begin
        run = RUN_W'($urandom_range(0, RUNS - 1));
        for (int i = 0; i < nbase; i++) begin
          sel = $urandom_range(0, 9);
          off = $urandom_range(0, span);
          if (sel < 8) begin
            send_item(OP_INSERT, run, $urandom_range(0, 1) ? bases[i] + off : bases[i] - off);
          end else if (sel < 9) begin
            send_item(OP_INSERT, run, $urandom);
          end
        end
      end
      send_item(OP_PRUNE, RUN_W'($urandom), $urandom);
      if ($urandom_range(0, 1)) begin
        send_item(OP_CLEAR, RUN_W'($urandom), $urandom);
      end
    end
  endtask

  // Fills the table, then drops, matches while full, and a full listing.
  task automatic test_table_full();
    settle();
    write_reg(REG_MZ_TOL, '0);
    write_reg(REG_MIN_RUNS, 32'd1);
    send_item(OP_CLEAR, RUN_W'($urandom), $urandom);
    for (int i = 0; i < TRACES + 6; i++) begin
      send_item(OP_INSERT, RUN_W'($urandom), $urandom);
    end
    for (int i = 0; i < 5; i++) begin
      send_item(OP_INSERT, RUN_W'($urandom),
                shadow_key[$urandom_range(0, shadow_total - 1)]);
    end
    send_item(OP_PRUNE, RUN_W'($urandom), $urandom);
    send_item(OP_INSERT, RUN_W'($urandom), $urandom);
    send_item(OP_CLEAR, RUN_W'($urandom), $urandom);
  endtask

  // Random mix of all ops, with a stretch of no stalls and some drained pauses.
  task automatic test_random_mix();
    int sel;
    int next_reconfig;
    int steady_end;
    next_reconfig = items_sent;
    steady_end = items_sent + 45;
    steady_flow = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_reconfig) begin
        settle();
        write_reg(REG_MZ_TOL, pick_tolerance());
        write_reg(REG_MIN_RUNS, $urandom_range(0, 6));
        next_reconfig = items_sent + 50;
      end
      if (items_sent >= steady_end) begin
        steady_flow = 1'b0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        send_item(OP_INSERT, RUN_W'($urandom), pick_mz());
      end else if (sel < 88) begin
        send_item(OP_PRUNE, RUN_W'($urandom), $urandom);
      end else if (sel < 92) begin
        send_item(OP_CLEAR, RUN_W'($urandom), $urandom);
      end else if (sel < 96) begin
        send_item(OP_UNUSED, RUN_W'($urandom), $urandom);
      end else if (!steady_flow) begin
        hold_until_drained();
      end
    end
    steady_flow = 1'b0;
  endtask

  // Main sequence.
  initial begin
    mismatch_count = 0;
    result_index = 0;
    items_sent = 0;
    steady_flow = 1'b0;
    shadow_total = 0;
    shadow_tol = TOL_RESET;
    shadow_min_runs = int'(MIN_RUNS_RESET);
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_INSERT;
    in_ch.run_id = '0;
    in_ch.fragment_mz = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_config_extremes();
    test_run_groups();
    test_table_full();
    test_random_mix();

    // Drain, with a bound of its own, then give the block time to go quiet.
    in_ch.valid <= 1'b0;
    for (int i = 0; i < 50000 && pending_results.size() != 0; i++) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("** tolerance_peak_trace_matcher_core: PASSED **");
    end else begin
      $display("** tolerance_peak_trace_matcher_core: FAILED **");
    end
    $finish;
  end

endmodule
